// ===== hdl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising edge outside reset
`define SPC_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must never hold
`define SPC_NEVER(name, clk, rst_n, cond, msg) \
  `SPC_ASSERT(name, clk, rst_n, !(cond), msg)

`endif

// ===== hdl/spc_pkg.sv =====
package spc_pkg;

  localparam int SW  = 40;  // accumulator width
  localparam int PW  = 7;   // phase count width
  localparam int WW  = 13;  // tile width / shift width
  localparam int DVW = 24;  // dividend width
  localparam int QW  = 25;  // signed quotient width
  localparam int MW  = 39;  // product width

  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_SPAN = 2'd1;
  localparam logic [1:0] OP_CLIP = 2'd2;

  localparam logic REG_PHASE_COUNT = 1'b0;
  localparam logic REG_SHIFT       = 1'b1;

  localparam logic signed [SW-1:0] ACC_HI = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] ACC_LO = {1'b1, {(SW-1){1'b0}}};

  localparam logic signed [SW-1:0] START_MAX = 40'sd16777215;
  localparam logic signed [SW-1:0] START_MIN = -40'sd16777216;
  localparam logic signed [SW-1:0] WIDTH_MAX = 40'sd33554431;
  localparam logic signed [SW-1:0] WIDTH_MIN = -40'sd16777216;

  typedef enum logic [1:0] {
    WALK_FULL,  // min start and max end, origin advances
    WALK_MIN,   // min offset only, first entry sets the end
    WALK_MAX    // max end only, origin advances
  } spc_walk_e;

  typedef struct packed {
    logic      capture;
    logic      load_wr;
    logic      acc_clear;
    logic      div_start;
    logic      div_sel_w;
    logic      div1_take;
    logic      div2_take;
    logic      mul_go;
    logic      mul_sel_cyc;
    logic      walk_start;
    spc_walk_e walk_mode;
    logic      base_take;
    logic      fin;
    logic      fin_clip;
    logic      out_load;
    logic      out_zero;
  } spc_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic walk_busy;
    logic out_free;
  } spc_sts_t;

endpackage

// ===== hdl/spc_ram.sv =====
module spc_ram #(
  parameter int WIDTH = 23,
  parameter int DEPTH = 64
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/spc_div.sv =====
`include "assert_macros.svh"

module spc_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [spc_pkg::DVW-1:0]   dividend_i,
  input  logic [spc_pkg::PW-1:0]    divisor_i,
  output logic                      busy_o,
  output logic [spc_pkg::DVW-1:0]   quot_o,
  output logic [spc_pkg::PW-1:0]    rem_o
);

  localparam int CW = $clog2(spc_pkg::DVW);

  logic                    busy_q, busy_d;
  logic [CW-1:0]           cnt_q, cnt_d;
  logic [spc_pkg::DVW-1:0] dvd_q, dvd_d;
  logic [spc_pkg::PW-1:0]  rem_q, rem_d;
  logic [spc_pkg::PW:0]    trial;
  logic                    ge;

  // one quotient bit per cycle, restoring
  always_comb begin
    trial  = {rem_q, dvd_q[spc_pkg::DVW-1]};
    ge     = (trial >= {1'b0, divisor_i});
    busy_d = busy_q;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dvd_d  = dividend_i;
      rem_d  = '0;
    end else if (busy_q) begin
      dvd_d = {dvd_q[spc_pkg::DVW-2:0], ge};
      rem_d = ge ? spc_pkg::PW'(trial - {1'b0, divisor_i}) : trial[spc_pkg::PW-1:0];
      cnt_d = cnt_q + CW'(1);
      if (cnt_q == CW'(spc_pkg::DVW - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
  end

  assign busy_o = busy_q;
  assign quot_o = dvd_q;
  assign rem_o  = rem_q;

  `SPC_ASSERT(a_div_start_busy, clk_i, rst_ni, start_i |=> busy_q, "divider idle after start")

endmodule

// ===== hdl/spc_dp.sv =====
`include "assert_macros.svh"

module spc_dp #(
  parameter int MAX_PHASES = 64,
  parameter int MAX_TILE   = 4096
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  spc_pkg::spc_cmd_t         cmd_i,
  output spc_pkg::spc_sts_t         sts_o,
  input  logic [spc_pkg::PW-1:0]    p_eff_i,
  input  logic [spc_pkg::WW-1:0]    shift_i,
  input  logic [5:0]                entry_index_i,
  input  logic signed [10:0]        entry_offset_i,
  input  logic [7:0]                entry_taps_i,
  input  logic signed [23:0]        dst_start_i,
  input  logic [12:0]               dst_width_i,
  input  logic [23:0]               src_total_width_i,
  input  logic                      m_tready_i,
  output logic                      m_tvalid_o,
  output logic signed [24:0]        src_start_o,
  output logic signed [25:0]        src_width_o
);

  localparam int SW = spc_pkg::SW;
  localparam int PW = spc_pkg::PW;
  localparam int WW = spc_pkg::WW;
  localparam int AW = (MAX_PHASES > 1) ? $clog2(MAX_PHASES) : 1;

  // captured query
  logic signed [23:0] dx_q;
  logic [WW-1:0]      w_q;
  logic [23:0]        total_q;
  logic [WW-1:0]      w_lim;

  always_comb begin
    if (32'(dst_width_i) > MAX_TILE) begin
      w_lim = WW'(MAX_TILE);
    end else begin
      w_lim = dst_width_i;
    end
    if (w_lim == '0) begin
      w_lim = WW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      dx_q    <= dst_start_i;
      w_q     <= w_lim;
      total_q <= src_total_width_i;
    end
  end

  // kernel table: end offset above start offset
  logic               ram_we;
  logic signed [11:0] end_rel;
  logic [22:0]        ram_rdata;
  logic signed [10:0] rd_off;
  logic signed [11:0] rd_end;
  logic [PW-1:0]      idx_q;

  assign ram_we  = cmd_i.load_wr && (32'(entry_index_i) < MAX_PHASES);
  assign end_rel = 12'(entry_offset_i) + 12'(entry_taps_i);
  assign rd_off  = ram_rdata[10:0];
  assign rd_end  = ram_rdata[22:11];

  spc_ram #(
    .WIDTH (23),
    .DEPTH (MAX_PHASES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (AW'(entry_index_i)),
    .wdata_i ({end_rel, entry_offset_i}),
    .raddr_i (AW'(idx_q)),
    .rdata_o (ram_rdata)
  );

  // divider
  logic [spc_pkg::DVW-1:0] dvd;
  logic [spc_pkg::DVW-1:0] quot;
  logic [PW-1:0]           rem;
  logic                    div_busy;

  assign dvd = cmd_i.div_sel_w ? spc_pkg::DVW'(w_q) : (dx_q[23] ? ~dx_q : dx_q);

  spc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dvd),
    .divisor_i  (p_eff_i),
    .busy_o     (div_busy),
    .quot_o     (quot),
    .rem_o      (rem)
  );

  // floored quotient, first phase and trailing-walk start
  logic signed [spc_pkg::QW-1:0] q_q;
  logic [PW-1:0]                 r_q, ib_q, ib_d;
  logic [WW-1:0]                 cyc_q, cyc_d, minw;
  logic [PW:0]                   ib_sum;

  assign minw   = (w_q < WW'(p_eff_i)) ? w_q : WW'(p_eff_i);
  assign ib_sum = {1'b0, r_q} + {1'b0, rem};

  always_comb begin
    if (w_q < WW'(p_eff_i)) begin
      cyc_d = '0;
      ib_d  = r_q;
    end else if (ib_sum >= {1'b0, p_eff_i}) begin
      cyc_d = quot[WW-1:0];
      ib_d  = PW'(ib_sum - {1'b0, p_eff_i});
    end else begin
      cyc_d = quot[WW-1:0] - WW'(1);
      ib_d  = ib_sum[PW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div1_take) begin
      q_q <= dx_q[23] ? ~{1'b0, quot} : {1'b0, quot};
      r_q <= dx_q[23] ? (p_eff_i - PW'(1) - rem) : rem;
    end
    if (cmd_i.div2_take) begin
      cyc_q <= cyc_d;
      ib_q  <= ib_d;
    end
  end

  // multiplier
  logic signed [spc_pkg::QW-1:0] mul_a;
  logic signed [WW:0]            mul_b;
  logic signed [spc_pkg::MW-1:0] mul_q, base_q;

  assign mul_a = cmd_i.mul_sel_cyc ? signed'(spc_pkg::QW'(cyc_q)) : q_q;
  assign mul_b = signed'({1'b0, shift_i});

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_go) begin
      mul_q <= mul_a * mul_b;
    end
    if (cmd_i.base_take) begin
      base_q <= mul_q;
    end
  end

  // table walk: read one entry a cycle, accumulate in the cycle after the read
  logic [WW-1:0]       cnt_q;
  logic                pv_q;
  logic                issue;
  logic signed [SW-1:0] org_q, porg_q;
  spc_pkg::spc_walk_e  mode_q;
  logic                first_q, pfirst_q;
  logic [PW-1:0]       idx_nx;

  assign issue  = (cnt_q != '0);
  assign idx_nx = idx_q + PW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      pv_q  <= 1'b0;
    end else begin
      pv_q <= issue;
      if (cmd_i.walk_start) begin
        cnt_q <= (cmd_i.walk_mode == spc_pkg::WALK_FULL) ? w_q : minw;
      end else if (issue) begin
        cnt_q <= cnt_q - WW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.walk_start) begin
      idx_q   <= (cmd_i.walk_mode == spc_pkg::WALK_MAX) ? ib_q : r_q;
      org_q   <= (cmd_i.walk_mode == spc_pkg::WALK_MIN) ? '0 : SW'(mul_q);
      mode_q  <= cmd_i.walk_mode;
      first_q <= 1'b1;
    end else if (issue) begin
      first_q <= 1'b0;
      if (idx_nx == p_eff_i) begin
        idx_q <= '0;
        if (mode_q != spc_pkg::WALK_MIN) begin
          org_q <= org_q + SW'(shift_i);
        end
      end else begin
        idx_q <= idx_nx;
      end
    end
    porg_q   <= org_q;
    pfirst_q <= first_q;
  end

  logic signed [SW-1:0] min_q, max_q, s_val, e_val;
  logic                 upd_min, upd_max;

  assign s_val   = porg_q + SW'(rd_off);
  assign e_val   = porg_q + SW'(rd_end);
  assign upd_min = (mode_q == spc_pkg::WALK_FULL) || (mode_q == spc_pkg::WALK_MIN);
  assign upd_max = (mode_q == spc_pkg::WALK_FULL) || (mode_q == spc_pkg::WALK_MAX) ||
                   ((mode_q == spc_pkg::WALK_MIN) && pfirst_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.acc_clear) begin
      min_q <= spc_pkg::ACC_HI;
      max_q <= spc_pkg::ACC_LO;
    end else if (pv_q) begin
      if (upd_min && (s_val < min_q)) begin
        min_q <= s_val;
      end
      if (upd_max && (e_val > max_q)) begin
        max_q <= e_val;
      end
    end
  end

  // final span and clipping
  logic signed [SW-1:0] cs, ce, tot_x, fs_q, fe_q;

  assign cs    = min_q + SW'(base_q);
  assign ce    = max_q + SW'(base_q);
  assign tot_x = SW'(total_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.fin) begin
      if (cmd_i.fin_clip) begin
        fs_q <= (cs < 0) ? '0 : cs;
        fe_q <= (ce > tot_x) ? tot_x : ce;
      end else begin
        fs_q <= min_q;
        fe_q <= max_q;
      end
    end
  end

  // output register
  logic signed [SW-1:0] sw_raw, fs_sat, sw_sat;
  logic                 m_valid_q;
  logic signed [24:0]   start_q;
  logic signed [25:0]   width_q;

  assign sw_raw = fe_q - fs_q;

  always_comb begin
    if (fs_q > spc_pkg::START_MAX) begin
      fs_sat = spc_pkg::START_MAX;
    end else if (fs_q < spc_pkg::START_MIN) begin
      fs_sat = spc_pkg::START_MIN;
    end else begin
      fs_sat = fs_q;
    end
    if (sw_raw > spc_pkg::WIDTH_MAX) begin
      sw_sat = spc_pkg::WIDTH_MAX;
    end else if (sw_raw < spc_pkg::WIDTH_MIN) begin
      sw_sat = spc_pkg::WIDTH_MIN;
    end else begin
      sw_sat = sw_raw;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      start_q <= cmd_i.out_zero ? '0 : fs_sat[24:0];
      width_q <= cmd_i.out_zero ? '0 : sw_sat[25:0];
    end
  end

  assign m_tvalid_o  = m_valid_q;
  assign src_start_o = start_q;
  assign src_width_o = width_q;

  assign sts_o.div_busy  = div_busy;
  assign sts_o.walk_busy = issue || pv_q;
  assign sts_o.out_free  = !m_valid_q || m_tready_i;

  `SPC_ASSERT(a_walk_idx_range, clk_i, rst_ni, issue |-> (idx_q < p_eff_i), "walk index beyond phase count")
  `SPC_ASSERT(a_walk_pipe, clk_i, rst_ni, pv_q |-> $past(issue), "table data without a read")

endmodule

// ===== hdl/spc_ctrl.sv =====
`include "assert_macros.svh"

module spc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_tvalid_i,
  output logic              s_tready_o,
  input  logic [1:0]        opcode_i,
  input  logic              dx_neg_i,
  input  spc_pkg::spc_sts_t sts_i,
  output spc_pkg::spc_cmd_t cmd_o
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_DIV1S = 4'd1;
  localparam logic [3:0] ST_DIV1  = 4'd2;
  localparam logic [3:0] ST_MUL1  = 4'd3;
  localparam logic [3:0] ST_WS1   = 4'd4;
  localparam logic [3:0] ST_WALK1 = 4'd5;
  localparam logic [3:0] ST_DIV2S = 4'd6;
  localparam logic [3:0] ST_DIV2  = 4'd7;
  localparam logic [3:0] ST_MUL2  = 4'd8;
  localparam logic [3:0] ST_WS2   = 4'd9;
  localparam logic [3:0] ST_WALK2 = 4'd10;
  localparam logic [3:0] ST_FIN   = 4'd11;
  localparam logic [3:0] ST_DONE  = 4'd12;
  localparam logic [3:0] ST_ZERO  = 4'd13;

  logic [3:0] state_q, state_d;
  logic       clip_q, clip_d;

  always_comb begin
    state_d    = state_q;
    clip_d     = clip_q;
    cmd_o      = '0;
    s_tready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_tready_o = 1'b1;
        if (s_tvalid_i) begin
          cmd_o.capture = 1'b1;
          clip_d        = (opcode_i == spc_pkg::OP_CLIP);
          if (opcode_i == spc_pkg::OP_LOAD) begin
            cmd_o.load_wr = 1'b1;
          end
          if ((opcode_i == spc_pkg::OP_SPAN) ||
              ((opcode_i == spc_pkg::OP_CLIP) && !dx_neg_i)) begin
            cmd_o.acc_clear = 1'b1;
            state_d         = ST_DIV1S;
          end else begin
            state_d = ST_ZERO;
          end
        end
      end
      ST_DIV1S: begin
        cmd_o.div_start = 1'b1;
        state_d         = ST_DIV1;
      end
      ST_DIV1: begin
        if (!sts_i.div_busy) begin
          cmd_o.div1_take = 1'b1;
          state_d         = ST_MUL1;
        end
      end
      ST_MUL1: begin
        cmd_o.mul_go = 1'b1;
        state_d      = ST_WS1;
      end
      ST_WS1: begin
        cmd_o.walk_start = 1'b1;
        cmd_o.walk_mode  = clip_q ? spc_pkg::WALK_MIN : spc_pkg::WALK_FULL;
        cmd_o.base_take  = 1'b1;
        state_d          = ST_WALK1;
      end
      ST_WALK1: begin
        if (!sts_i.walk_busy) begin
          state_d = clip_q ? ST_DIV2S : ST_FIN;
        end
      end
      ST_DIV2S: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel_w = 1'b1;
        state_d         = ST_DIV2;
      end
      ST_DIV2: begin
        if (!sts_i.div_busy) begin
          cmd_o.div2_take = 1'b1;
          state_d         = ST_MUL2;
        end
      end
      ST_MUL2: begin
        cmd_o.mul_go      = 1'b1;
        cmd_o.mul_sel_cyc = 1'b1;
        state_d           = ST_WS2;
      end
      ST_WS2: begin
        cmd_o.walk_start = 1'b1;
        cmd_o.walk_mode  = spc_pkg::WALK_MAX;
        state_d          = ST_WALK2;
      end
      ST_WALK2: begin
        if (!sts_i.walk_busy) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        cmd_o.fin      = 1'b1;
        cmd_o.fin_clip = clip_q;
        state_d        = ST_DONE;
      end
      ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      ST_ZERO: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_zero = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      clip_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clip_q  <= clip_d;
    end
  end

  `SPC_ASSERT(a_out_when_free, clk_i, rst_ni, cmd_o.out_load |-> sts_i.out_free, "result loaded over a waiting one")
  `SPC_NEVER(a_idle_walk, clk_i, rst_ni, s_tready_o && sts_i.walk_busy, "item taken during a table walk")

endmodule

// ===== hdl/polyphase_source_span_calc.sv =====
// load, unused opcode and negative clipped start return a zero result without a divider pass
// unclipped query: one divider pass and a table walk over w entries, w the tile width after
// saturation (0 counts as 1); clipped query: two divider passes and two walks over min(w, phases)
// entries each; both use the serial divider and the table walk, which reads one entry a cycle
// throughput: one item at a time; the next item is taken the cycle after a result is loaded
// reset: config to 1, control cleared; the kernel table holds nothing until loaded
module polyphase_source_span_calc #(
  parameter int MAX_PHASES = 64,
  parameter int MAX_TILE   = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // entry_index, entry_offset, entry_taps, dst_start, dst_width, src_total_width, pad
  input  logic [87:0] s_axis_tdata,
  // opcode
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // src_start, src_width, pad
  output logic [55:0] m_axis_tdata,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [12:0] cfg_data_i
);

  localparam int PW = spc_pkg::PW;

  // configuration registers
  logic [PW-1:0]          pc_q;
  logic [spc_pkg::WW-1:0] shift_q;
  logic [PW-1:0]          p_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q    <= PW'(1);
      shift_q <= spc_pkg::WW'(1);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        spc_pkg::REG_PHASE_COUNT: pc_q    <= cfg_data_i[PW-1:0];
        spc_pkg::REG_SHIFT:       shift_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  always_comb begin
    if (pc_q == '0) begin
      p_eff = PW'(1);
    end else if (32'(pc_q) > MAX_PHASES) begin
      p_eff = PW'(MAX_PHASES);
    end else begin
      p_eff = pc_q;
    end
  end

  spc_pkg::spc_cmd_t  cmd;
  spc_pkg::spc_sts_t  sts;
  logic signed [24:0] src_start;
  logic signed [25:0] src_width;

  spc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .opcode_i   (s_axis_tuser),
    .dx_neg_i   (s_axis_tdata[48]),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  spc_dp #(
    .MAX_PHASES (MAX_PHASES),
    .MAX_TILE   (MAX_TILE)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .p_eff_i           (p_eff),
    .shift_i           (shift_q),
    .entry_index_i     (s_axis_tdata[5:0]),
    .entry_offset_i    (signed'(s_axis_tdata[16:6])),
    .entry_taps_i      (s_axis_tdata[24:17]),
    .dst_start_i       (signed'(s_axis_tdata[48:25])),
    .dst_width_i       (s_axis_tdata[61:49]),
    .src_total_width_i (s_axis_tdata[85:62]),
    .m_tready_i        (m_axis_tready),
    .m_tvalid_o        (m_axis_tvalid),
    .src_start_o       (src_start),
    .src_width_o       (src_width)
  );

  assign m_axis_tdata = {5'b0, src_width, src_start};

endmodule
